>>> hw/rtl/ubfe_pkg.sv
// shared types and constants for the buffered uart front end
package ubfe_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEVEL_W = 7;

    // event kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_HOST_WRITE = 2'd0,
        ACT_HOST_READ  = 2'd1,
        ACT_LINE_RX    = 2'd2,
        ACT_TX_READY   = 2'd3
    } action_t;

    // fifo status seen by the front end control
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

>>> hw/rtl/uart_buffered_tx_rx_front_end.sv
// buffered uart front end: transmit and receive byte fifos with holding register control
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   data[7:0]                               action[1:0]
//  m_axis    out  line_byte, read_byte, write_accepted,   line_valid, read_valid
//                 rx_dropped, rx_level, tx_level
//
//  one item per cycle unless m_axis stalls; items pass the pending then the result register
//  the pending stage covers the registered read of the fifo rams
//  rst_n clears pointers, fill counts, stage valid flags, holding-empty (set), send irq enable
//  fifo contents are not cleared; only written entries are ever read
//  a stall on m_axis fills the pending stage and then drops s_axis_tready
module uart_buffered_tx_rx_front_end #(
    parameter int unsigned TX_DEPTH = 64,
    parameter int unsigned RX_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data[7:0]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // line_byte[7:0], read_byte[15:8], write_accepted[16],
                                        // rx_dropped[17], rx_level[24:18], tx_level[31:25]
    output logic [1:0]  m_axis_tuser    // line_valid[0], read_valid[1]
);

    localparam int unsigned BW  = ubfe_pkg::BYTE_W;
    localparam int unsigned LW  = ubfe_pkg::LEVEL_W;
    localparam int unsigned TFW = $clog2(TX_DEPTH + 1);
    localparam int unsigned RFW = $clog2(RX_DEPTH + 1);

    // pending stage: control decided, ram read in flight
    typedef struct packed {
        logic          line_valid;
        logic          line_from_fifo;
        logic [BW-1:0] line_direct;
        logic          read_valid;
        logic          write_accepted;
        logic          rx_dropped;
        logic [LW-1:0] rx_level;
        logic [LW-1:0] tx_level;
    } pend_t;

    ubfe_pkg::action_t    action;
    ubfe_pkg::fifo_stat_t tx_stat;
    ubfe_pkg::fifo_stat_t rx_stat;

    logic           accept;
    logic           pend_move;
    logic           pend_valid_reg;
    pend_t          pend_reg, pend_next;
    logic           out_valid_reg;
    logic [31:0]    out_data_reg;
    logic [1:0]     out_user_reg;

    logic           holding_empty_reg, holding_empty_next;
    logic           send_irq_en_reg, send_irq_en_next;  // mirrors the send interrupt enable

    logic           tx_push, tx_pop, rx_push, rx_pop;
    logic [BW-1:0]  tx_rdata, rx_rdata;
    logic [TFW-1:0] tx_fill_next;
    logic [RFW-1:0] rx_fill_next;

    logic [BW-1:0]  line_byte, read_byte;

    assign action = ubfe_pkg::action_t'(s_axis_tuser);

    // pending stage moves when the output register is free or being drained
    assign pend_move     = pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !pend_valid_reg || pend_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // event decode: one push or pop per fifo at most
    always_comb
    begin
        holding_empty_next       = holding_empty_reg;
        send_irq_en_next         = send_irq_en_reg;
        tx_push                  = 1'b0;
        tx_pop                   = 1'b0;
        rx_push                  = 1'b0;
        rx_pop                   = 1'b0;
        pend_next                = '0;
        pend_next.line_direct    = s_axis_tdata;
        if (accept)
        begin
            unique case (action)
                ubfe_pkg::ACT_HOST_WRITE:
                begin
                    if (holding_empty_reg && tx_stat.empty)
                    begin
                        // straight into the holding register
                        holding_empty_next       = 1'b0;
                        pend_next.line_valid     = 1'b1;
                        pend_next.write_accepted = 1'b1;
                    end
                    else
                    begin
                        // queue it; a full fifo refuses but still enables send irq
                        send_irq_en_next         = 1'b1;
                        tx_push                  = !tx_stat.full;
                        pend_next.write_accepted = !tx_stat.full;
                    end
                end
                ubfe_pkg::ACT_HOST_READ:
                begin
                    rx_pop               = !rx_stat.empty;
                    pend_next.read_valid = !rx_stat.empty;
                end
                ubfe_pkg::ACT_LINE_RX:
                begin
                    rx_push              = !rx_stat.full;
                    pend_next.rx_dropped = rx_stat.full;
                end
                ubfe_pkg::ACT_TX_READY:
                begin
                    if (!tx_stat.empty)
                    begin
                        // refill the holding register from the fifo
                        tx_pop                   = 1'b1;
                        holding_empty_next       = 1'b0;
                        pend_next.line_valid     = 1'b1;
                        pend_next.line_from_fifo = 1'b1;
                    end
                    else
                    begin
                        holding_empty_next = 1'b1;
                        send_irq_en_next   = 1'b0;
                    end
                end
                default:
                begin
                    holding_empty_next = holding_empty_reg;
                end
            endcase
        end
        // levels after this event, reported modulo 128
        pend_next.rx_level = LW'(rx_fill_next);
        pend_next.tx_level = LW'(tx_fill_next);
    end

    ubfe_fifo #(
        .DEPTH (TX_DEPTH)
    ) u_tx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tx_push),
        .pop       (tx_pop),
        .wdata     (s_axis_tdata),
        .rdata     (tx_rdata),
        .stat      (tx_stat),
        .fill_next (tx_fill_next)
    );

    ubfe_fifo #(
        .DEPTH (RX_DEPTH)
    ) u_rx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rx_push),
        .pop       (rx_pop),
        .wdata     (s_axis_tdata),
        .rdata     (rx_rdata),
        .stat      (rx_stat),
        .fill_next (rx_fill_next)
    );

    // ram read data is held until the next pop, and no pop happens while pending stalls
    always_comb
    begin
        line_byte = '0;
        if (pend_reg.line_valid)
        begin
            line_byte = pend_reg.line_from_fifo ? tx_rdata : pend_reg.line_direct;
        end
        read_byte = pend_reg.read_valid ? rx_rdata : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_empty_reg <= 1'b1;
            send_irq_en_reg   <= 1'b0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            holding_empty_reg <= holding_empty_next;
            send_irq_en_reg   <= send_irq_en_next;
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend_next;
        end
        if (pend_move)
        begin
            out_data_reg <= {pend_reg.tx_level, pend_reg.rx_level,
                             pend_reg.rx_dropped, pend_reg.write_accepted,
                             read_byte, line_byte};
            out_user_reg <= {pend_reg.read_valid, pend_reg.line_valid};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

>>> hw/rtl/ubfe_ram.sv
// generic single write port ram with registered read
module ubfe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds between reads
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ubfe_fifo.sv
// byte fifo: head, tail and fill count around one ram
module ubfe_fifo #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          pop,
    input  logic [ubfe_pkg::BYTE_W-1:0]   wdata,
    output logic [ubfe_pkg::BYTE_W-1:0]   rdata,
    output ubfe_pkg::fifo_stat_t          stat,
    output logic [$clog2(DEPTH+1)-1:0]    fill_next
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg;

    // callers only push when not full and pop when not empty
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (push)
        begin
            tail_next = (tail_reg == LAST_ADDR) ? '0 : tail_reg + AW'(1);
            fill_next = fill_reg + FW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FULL_FILL);

    ubfe_ram #(
        .WIDTH (ubfe_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (wdata),
        .re    (pop),
        .raddr (head_reg),
        .rdata (rdata)
    );

endmodule
